FILE: hdl/rpsd_pkg.sv
// Shared types and constants for the RefPack stream decoder.
// Parse phase codes, status codes, and the front-to-back item type.
// No dependencies.
package rpsd_pkg;

    localparam int HistAw = 17;

    localparam logic [3:0] PH_H0    = 4'd0;
    localparam logic [3:0] PH_H1    = 4'd1;
    localparam logic [3:0] PH_S0    = 4'd2;
    localparam logic [3:0] PH_S1    = 4'd3;
    localparam logic [3:0] PH_S2    = 4'd4;
    localparam logic [3:0] PH_CTRL  = 4'd5;
    localparam logic [3:0] PH_EXTRA = 4'd6;
    localparam logic [3:0] PH_LIT   = 4'd7;
    localparam logic [3:0] PH_COPY  = 4'd8;
    localparam logic [3:0] PH_DRAIN = 4'd9;

    localparam logic [3:0] ST_RUN     = 4'd0;
    localparam logic [3:0] ST_OK      = 4'd1;
    localparam logic [3:0] ST_HDR     = 4'd2;
    localparam logic [3:0] ST_CMD     = 4'd4;
    localparam logic [3:0] ST_LIT     = 4'd5;
    localparam logic [3:0] ST_REF     = 4'd6;
    localparam logic [3:0] ST_SIZE    = 4'd7;
    localparam logic [3:0] ST_REFUSED = 4'd8;

    // work item from front to back
    typedef struct packed {
        logic              rd;       // history read needed
        logic [HistAw-1:0] rd_addr;
        logic              wr;       // byte produced
        logic              lit;      // byte comes from lit_byte
        logic [7:0]        lit_byte;
        logic [HistAw-1:0] wr_addr;
        logic [3:0]        status;
        logic              stream_end;
    } work_t;

endpackage

FILE: hdl/rpsd_front.sv
// Front end: parses the RefPack stream, keeps all decode state,
// and emits one work item per accepted input. Uses rpsd_pkg.
module rpsd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                cmd,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output logic                w_valid,
    input  logic                w_ready,
    output rpsd_pkg::work_t     w_item
);

    logic [3:0]  phase_reg, phase_next;
    logic [23:0] prod_reg, prod_next;
    logic [23:0] exp_reg, exp_next;
    logic [31:0] cb_reg, cb_next;
    logic [6:0]  lits_reg, lits_next;
    logic [10:0] copy_reg, copy_next;
    logic [17:0] dist_reg, dist_next;
    logic        stop_reg, stop_next;
    logic [3:0]  verd_reg, verd_next;
    logic        lseen_reg, lseen_next;
    logic [2:0]  have_reg, have_next;
    logic        take;
    rpsd_pkg::work_t item;

    assign in_ready = w_ready;
    assign w_valid  = in_valid;
    assign take     = in_valid && w_ready;
    assign w_item   = item;

    function automatic logic [2:0] clen(input logic [7:0] c);
        if (!c[7]) return 3'd2;
        if (!c[6]) return 3'd3;
        if (!c[5]) return 3'd4;
        return 3'd1;
    endfunction

    always_comb begin
        logic [23:0] rem;
        logic [31:0] cbw;
        logic [7:0]  c, b1, b2, b3;
        logic [6:0]  lit;
        logic [10:0] cl;
        logic [17:0] cd;
        logic [24:0] dpos;
        logic        stp, fin, vlast, vgive;
        logic [3:0]  vcode;
        phase_next = phase_reg; prod_next = prod_reg; exp_next = exp_reg;
        cb_next = cb_reg; lits_next = lits_reg; copy_next = copy_reg;
        dist_next = dist_reg; stop_next = stop_reg; verd_next = verd_reg;
        lseen_next = lseen_reg; have_next = have_reg;
        item = '0;
        item.status = rpsd_pkg::ST_RUN;
        item.wr_addr = prod_reg[rpsd_pkg::HistAw-1:0];
        rem = (exp_reg >= prod_reg) ? exp_reg - prod_reg : 24'd0;
        cbw = cb_reg; lit = '0; cl = '0; cd = '0; stp = stop_reg;
        fin = 1'b0; vgive = 1'b0; vcode = rpsd_pkg::ST_RUN; vlast = in_last;
        c = 8'd0; b1 = 8'd0; b2 = 8'd0; b3 = 8'd0;
        dpos = '0;
        if (cmd) begin
            dpos = {1'b0, prod_reg} - {7'd0, dist_reg};
            if (phase_reg != rpsd_pkg::PH_COPY || copy_reg == 11'd0 || dist_reg == 18'd0
                || {6'd0, dist_reg} > prod_reg) begin
                item.status = rpsd_pkg::ST_REFUSED;
            end else begin
                item.rd = 1'b1;
                item.wr = 1'b1;
                item.rd_addr = dpos[rpsd_pkg::HistAw-1:0];
                prod_next = prod_reg + 24'd1;
                copy_next = copy_reg - 11'd1;
                if (copy_reg == 11'd1) begin
                    dist_next = '0;
                    if (lseen_reg) begin
                        vgive = 1'b1; vcode = rpsd_pkg::ST_SIZE; vlast = 1'b1;
                    end else begin
                        phase_next = rpsd_pkg::PH_CTRL;
                    end
                end
            end
        end else if (phase_reg == rpsd_pkg::PH_COPY) begin
            item.status = rpsd_pkg::ST_REFUSED;
        end else begin
            unique case (phase_reg)
                rpsd_pkg::PH_H0: begin
                    if (in_byte != 8'h10 || in_last) begin
                        vgive = 1'b1; vcode = rpsd_pkg::ST_HDR;
                    end else phase_next = rpsd_pkg::PH_H1;
                end
                rpsd_pkg::PH_H1: begin
                    if (in_byte != 8'hFB || in_last) begin
                        vgive = 1'b1; vcode = rpsd_pkg::ST_HDR;
                    end else phase_next = rpsd_pkg::PH_S0;
                end
                rpsd_pkg::PH_S0, rpsd_pkg::PH_S1: begin
                    exp_next = {exp_reg[15:0], in_byte};
                    if (in_last) begin
                        vgive = 1'b1; vcode = rpsd_pkg::ST_HDR;
                    end else phase_next = phase_reg + 4'd1;
                end
                rpsd_pkg::PH_S2: begin
                    exp_next = {exp_reg[15:0], in_byte};
                    if (in_last) begin
                        vgive = 1'b1; vcode = rpsd_pkg::ST_SIZE;
                    end else phase_next = rpsd_pkg::PH_CTRL;
                end
                rpsd_pkg::PH_CTRL: begin
                    cbw = {24'd0, in_byte};
                    cb_next = cbw;
                    have_next = 3'd1;
                    if (clen(in_byte) == 3'd1) fin = 1'b1;
                    else if (in_last) begin
                        vgive = 1'b1; vcode = rpsd_pkg::ST_CMD;
                    end else phase_next = rpsd_pkg::PH_EXTRA;
                end
                rpsd_pkg::PH_EXTRA: begin
                    unique case (have_reg[1:0])
                        2'd1: cbw = {cb_reg[31:16], in_byte, cb_reg[7:0]};
                        2'd2: cbw = {cb_reg[31:24], in_byte, cb_reg[15:0]};
                        2'd3: cbw = {in_byte, cb_reg[23:0]};
                        default: cbw = {cb_reg[31:8], in_byte};
                    endcase
                    cb_next = cbw;
                    have_next = have_reg + 3'd1;
                    if (have_reg + 3'd1 >= clen(cb_reg[7:0])) fin = 1'b1;
                    else if (in_last) begin
                        vgive = 1'b1; vcode = rpsd_pkg::ST_CMD;
                    end
                end
                rpsd_pkg::PH_LIT: begin
                    if (lits_reg > 7'd1 && in_last) begin
                        vgive = 1'b1; vcode = rpsd_pkg::ST_LIT;
                    end else begin
                        item.wr = 1'b1; item.lit = 1'b1; item.lit_byte = in_byte;
                        prod_next = prod_reg + 24'd1;
                        lits_next = lits_reg - 7'd1;
                        if (lits_reg <= 7'd1) begin
                            lits_next = '0;
                            // after literals, with produced count advanced
                            if (copy_reg != 11'd0) begin
                                if (dist_reg == 18'd0 || {6'd0, dist_reg} > prod_next ||
                                    {13'd0, copy_reg} > ((exp_reg >= prod_next) ?
                                    exp_reg - prod_next : 24'd0)) begin
                                    vgive = 1'b1; vcode = rpsd_pkg::ST_REF;
                                end else begin
                                    if (in_last) lseen_next = 1'b1;
                                    phase_next = rpsd_pkg::PH_COPY;
                                end
                            end else if (stop_reg) begin
                                vgive = 1'b1;
                                vcode = (prod_next == exp_reg) ? rpsd_pkg::ST_OK
                                                               : rpsd_pkg::ST_SIZE;
                            end else if (in_last) begin
                                vgive = 1'b1; vcode = rpsd_pkg::ST_SIZE;
                            end else phase_next = rpsd_pkg::PH_CTRL;
                        end
                    end
                end
                default: begin
                    item.status = verd_reg;
                    if (in_last) begin
                        phase_next = rpsd_pkg::PH_H0; prod_next = '0; exp_next = '0;
                        cb_next = '0; lits_next = '0; copy_next = '0; dist_next = '0;
                        stop_next = 1'b0; verd_next = '0; lseen_next = 1'b0;
                        have_next = '0;
                    end
                end
            endcase
            if (fin) begin
                c = cbw[7:0]; b1 = cbw[15:8]; b2 = cbw[23:16]; b3 = cbw[31:24];
                if (!c[7]) begin
                    lit = {5'd0, c[1:0]};
                    cl = {8'd0, c[4:2]} + 11'd3;
                    cd = 18'd1 + {10'd0, b1} + {8'd0, c[6:5], 8'd0};
                end else if (!c[6]) begin
                    lit = {5'd0, b1[7:6]};
                    cl = {5'd0, c[5:0]} + 11'd4;
                    cd = 18'd1 + {4'd0, b1[5:0], b2};
                end else if (!c[5]) begin
                    lit = {5'd0, c[1:0]};
                    cl = {1'b0, c[3:2], b3} + 11'd5;
                    cd = 18'd1 + {1'b0, c[4], b1, b2};
                end else if (c < 8'hFC) begin
                    lit = {c[4:0], 2'b00} + 7'd4;
                end else begin
                    lit = {5'd0, c[1:0]};
                    stp = 1'b1;
                end
                copy_next = cl; dist_next = cd; stop_next = stp;
                if ({17'd0, lit} > rem) begin
                    vgive = 1'b1; vcode = rpsd_pkg::ST_LIT;
                end else if (lit != 7'd0) begin
                    if (in_last) begin
                        vgive = 1'b1; vcode = rpsd_pkg::ST_LIT;
                    end else begin
                        lits_next = lit; phase_next = rpsd_pkg::PH_LIT;
                    end
                end else if (cl != 11'd0) begin
                    if (cd == 18'd0 || {6'd0, cd} > prod_reg || {13'd0, cl} > rem) begin
                        vgive = 1'b1; vcode = rpsd_pkg::ST_REF;
                    end else begin
                        if (in_last) lseen_next = 1'b1;
                        phase_next = rpsd_pkg::PH_COPY;
                    end
                end else if (stp) begin
                    vgive = 1'b1;
                    vcode = (prod_reg == exp_reg) ? rpsd_pkg::ST_OK : rpsd_pkg::ST_SIZE;
                end else if (in_last) begin
                    vgive = 1'b1; vcode = rpsd_pkg::ST_SIZE;
                end else phase_next = rpsd_pkg::PH_CTRL;
            end
        end
        if (vgive) begin
            item.status = vcode;
            item.stream_end = 1'b1;
            if (vlast) begin
                phase_next = rpsd_pkg::PH_H0; prod_next = '0; exp_next = '0;
                cb_next = '0; lits_next = '0; copy_next = '0; dist_next = '0;
                stop_next = 1'b0; verd_next = '0; lseen_next = 1'b0; have_next = '0;
            end else begin
                verd_next = vcode;
                phase_next = rpsd_pkg::PH_DRAIN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= rpsd_pkg::PH_H0; prod_reg <= '0; exp_reg <= '0;
            cb_reg <= '0; lits_reg <= '0; copy_reg <= '0; dist_reg <= '0;
            stop_reg <= 1'b0; verd_reg <= '0; lseen_reg <= 1'b0; have_reg <= '0;
        end else if (take) begin
            phase_reg <= phase_next; prod_reg <= prod_next; exp_reg <= exp_next;
            cb_reg <= cb_next; lits_reg <= lits_next; copy_reg <= copy_next;
            dist_reg <= dist_next; stop_reg <= stop_next; verd_reg <= verd_next;
            lseen_reg <= lseen_next; have_reg <= have_next;
        end
    end

endmodule

FILE: hdl/rpsd_fifo.sv
// Two-entry queue of work items between front and back.
// Uses rpsd_pkg.
module rpsd_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            i_valid,
    output logic            i_ready,
    input  rpsd_pkg::work_t i_item,
    output logic            o_valid,
    input  logic            o_ready,
    output rpsd_pkg::work_t o_item
);

    rpsd_pkg::work_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign i_ready = cnt_reg != 2'd2;
    assign o_valid = cnt_reg != 2'd0;
    assign o_item  = mem_reg[rp_reg];
    assign push    = i_valid && i_ready;
    assign pop     = o_valid && o_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= i_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

FILE: hdl/rpsd_back.sv
// Back end: history RAM with read-after-write forwarding and output register.
// Uses rpsd_pkg.
module rpsd_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            w_valid,
    output logic            w_ready,
    input  rpsd_pkg::work_t w_item,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_out_valid,
    output logic [3:0]      m_status,
    output logic            m_stream_end
);

    logic [7:0] hist [2**rpsd_pkg::HistAw];
    logic [7:0] rdata_reg;
    logic       ov_reg, ow_reg, olit_reg, oend_reg, fwd_reg;
    logic [7:0] olb_reg;
    logic [3:0] ost_reg;
    logic [rpsd_pkg::HistAw-1:0] owa_reg;
    logic       take;
    logic [7:0] obyte;

    assign w_ready = !ov_reg || m_ready;
    assign take    = w_valid && w_ready;
    assign obyte   = olit_reg ? olb_reg : (fwd_reg ? olb_reg : rdata_reg);

    assign m_valid      = ov_reg;
    assign m_out_byte   = ow_reg ? obyte : 8'd0;
    assign m_out_valid  = ow_reg;
    assign m_status     = ost_reg;
    assign m_stream_end = oend_reg;

    // write the byte held in the output stage; forward it to a read of the same entry
    always_ff @(posedge aclk) begin
        if (take && w_item.rd) rdata_reg <= hist[w_item.rd_addr];
        if (ov_reg && ow_reg) hist[owa_reg] <= obyte;
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            ow_reg <= w_item.wr;
            olit_reg <= w_item.lit;
            ost_reg <= w_item.status;
            oend_reg <= w_item.stream_end;
            owa_reg <= w_item.wr_addr;
            fwd_reg <= ov_reg && ow_reg && w_item.rd && (owa_reg == w_item.rd_addr);
            olb_reg <= w_item.lit ? w_item.lit_byte : obyte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (take) begin
            ov_reg <= 1'b1;
        end else if (m_ready) begin
            ov_reg <= 1'b0;
        end
    end

endmodule

FILE: hdl/refpack_stream_decoder_core.sv
// RefPack stream decoder top level: front parser, work queue, history back end.
// Input transfers reach the result through the queue and then the output register.
// Throughput: one item per cycle unless m_ready stalls; the history RAM reads and writes
// once per cycle, and the last produced byte is forwarded to a copy reading it straight away.
// Reset: synchronous active-low aresetn clears control state; history holds no reset.
module refpack_stream_decoder_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_cmd,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_valid,
    output logic [3:0] m_status,
    output logic       m_stream_end
);

    logic            fv, fr, bv, br;
    rpsd_pkg::work_t fi, bi;

    rpsd_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_valid), .in_ready(s_ready),
        .cmd(s_cmd), .in_byte(s_in_byte), .in_last(s_in_last),
        .w_valid(fv), .w_ready(fr), .w_item(fi)
    );

    rpsd_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn), .i_valid(fv), .i_ready(fr), .i_item(fi),
        .o_valid(bv), .o_ready(br), .o_item(bi)
    );

    rpsd_back u_back (
        .aclk(aclk), .aresetn(aresetn), .w_valid(bv), .w_ready(br), .w_item(bi),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_byte(m_out_byte),
        .m_out_valid(m_out_valid), .m_status(m_status), .m_stream_end(m_stream_end)
    );

endmodule

FILE: dv/refpack_stream_decoder_core_tb.sv
// Testbench for the RefPack stream decoder core: directed and random streams with pulls.
// Holds its own decoder state and history, compares every result transfer in order.
// Depends on rpsd_pkg and refpack_stream_decoder_core.
module refpack_stream_decoder_core_tb;

    localparam int HIST_DEPTH = 131072;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       byte_valid;
        logic [3:0] status;
        logic       ends;
    } dec_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_cmd = 1'b0;
    logic [7:0] s_in_byte = 8'd0;
    logic s_in_last = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic m_out_valid;
    logic [3:0] m_status;
    logic m_stream_end;

    refpack_stream_decoder_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_in_byte(s_in_byte), .s_in_last(s_in_last),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_byte(m_out_byte),
        .m_out_valid(m_out_valid), .m_status(m_status), .m_stream_end(m_stream_end)
    );

    // decoder state
    logic [7:0]  hist [HIST_DEPTH];
    logic [23:0] produced, exp_size;
    logic [3:0]  phase;
    logic [31:0] cmd_word;
    int unsigned lits_left, copy_left, copy_dist, cmd_have;
    logic        stop_seen, last_seen;
    logic [3:0]  verdict;
    dec_result_t res;

    item_t       pending_items[$];
    dec_result_t expected_bytes[$];
    int          errors = 0;
    bit          stim_done = 0;
    int          idle_cycles = 0;
    int          src_gap = 0, snk_gap = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic restart();
        produced = 0; exp_size = 0; phase = rpsd_pkg::PH_H0; cmd_word = 0;
        lits_left = 0; copy_left = 0; copy_dist = 0; cmd_have = 0;
        stop_seen = 0; last_seen = 0; verdict = rpsd_pkg::ST_RUN;
    endtask

    task automatic conclude(input logic [3:0] code, input logic last);
        verdict = code;
        res.status = code;
        res.ends = 1'b1;
        if (last) restart();
        else phase = rpsd_pkg::PH_DRAIN;
    endtask

    function automatic int unsigned left_to_go();
        return (exp_size >= produced) ? exp_size - produced : 0;
    endfunction

    task automatic emit(input logic [7:0] b);
        hist[produced % HIST_DEPTH] = b;
        produced = produced + 1;
        res.byte_out = b;
        res.byte_valid = 1'b1;
    endtask

    task automatic literals_finished(input logic last);
        if (copy_left != 0) begin
            if (copy_dist == 0 || copy_dist > produced || copy_left > left_to_go()) begin
                conclude(rpsd_pkg::ST_REF, last);
                return;
            end
            if (last) last_seen = 1'b1;
            phase = rpsd_pkg::PH_COPY;
        end else if (stop_seen) begin
            conclude(produced == exp_size ? rpsd_pkg::ST_OK : rpsd_pkg::ST_SIZE, last);
        end else if (last) begin
            conclude(rpsd_pkg::ST_SIZE, 1'b1);
        end else begin
            phase = rpsd_pkg::PH_CTRL;
        end
    endtask

    function automatic int unsigned form_len(input logic [7:0] c);
        if (c < 8'h80) return 2;
        if (c < 8'hC0) return 3;
        if (c < 8'hE0) return 4;
        return 1;
    endfunction

    task automatic decode_word(input logic last);
        logic [7:0] c, b1, b2, b3;
        int unsigned lit;
        c = cmd_word[7:0]; b1 = cmd_word[15:8]; b2 = cmd_word[23:16]; b3 = cmd_word[31:24];
        copy_left = 0; copy_dist = 0;
        if (c < 8'h80) begin
            lit = c & 3;
            copy_left = ((c >> 2) & 7) + 3;
            copy_dist = 1 + b1 + ((c & 8'h60) << 3);
        end else if (c < 8'hC0) begin
            lit = b1 >> 6;
            copy_left = (c & 8'h3F) + 4;
            copy_dist = 1 + ((b1 & 8'h3F) << 8) + b2;
        end else if (c < 8'hE0) begin
            lit = c & 3;
            copy_left = ((c & 8'h0C) << 6) + b3 + 5;
            copy_dist = 1 + ((c & 8'h10) << 12) + (b1 << 8) + b2;
        end else if (c < 8'hFC) begin
            lit = 4 * (c & 8'h1F) + 4;
        end else begin
            lit = c & 3;
            stop_seen = 1'b1;
        end
        if (lit > left_to_go()) begin
            conclude(rpsd_pkg::ST_LIT, last);
            return;
        end
        if (lit != 0) begin
            if (last) begin
                conclude(rpsd_pkg::ST_LIT, 1'b1);
                return;
            end
            lits_left = lit;
            phase = rpsd_pkg::PH_LIT;
            return;
        end
        literals_finished(last);
    endtask

    task automatic predict(input item_t it);
        logic [7:0] b;
        res = '0;
        b = it.data;
        if (it.cmd) begin
            if (phase != rpsd_pkg::PH_COPY || copy_left == 0 || copy_dist == 0 ||
                copy_dist > produced) begin
                res.status = rpsd_pkg::ST_REFUSED;
            end else begin
                emit(hist[(produced - copy_dist) % HIST_DEPTH]);
                copy_left--;
                if (copy_left == 0) begin
                    copy_dist = 0;
                    if (last_seen) conclude(rpsd_pkg::ST_SIZE, 1'b1);
                    else phase = rpsd_pkg::PH_CTRL;
                end
            end
        end else if (phase == rpsd_pkg::PH_COPY) begin
            res.status = rpsd_pkg::ST_REFUSED;
        end else begin
            case (phase)
                rpsd_pkg::PH_H0: begin
                    if (b != 8'h10 || it.last) conclude(rpsd_pkg::ST_HDR, it.last);
                    else phase = rpsd_pkg::PH_H1;
                end
                rpsd_pkg::PH_H1: begin
                    if (b != 8'hFB || it.last) conclude(rpsd_pkg::ST_HDR, it.last);
                    else phase = rpsd_pkg::PH_S0;
                end
                rpsd_pkg::PH_S0, rpsd_pkg::PH_S1: begin
                    exp_size = {exp_size[15:0], b};
                    if (it.last) conclude(rpsd_pkg::ST_HDR, 1'b1);
                    else phase = phase + 1;
                end
                rpsd_pkg::PH_S2: begin
                    exp_size = {exp_size[15:0], b};
                    if (it.last) conclude(rpsd_pkg::ST_SIZE, 1'b1);
                    else phase = rpsd_pkg::PH_CTRL;
                end
                rpsd_pkg::PH_CTRL: begin
                    cmd_word = {24'd0, b};
                    cmd_have = 1;
                    if (form_len(b) == 1) decode_word(it.last);
                    else if (it.last) conclude(rpsd_pkg::ST_CMD, 1'b1);
                    else phase = rpsd_pkg::PH_EXTRA;
                end
                rpsd_pkg::PH_EXTRA: begin
                    cmd_word = cmd_word | (32'(b) << (8 * (cmd_have & 3)));
                    cmd_have++;
                    if (cmd_have >= form_len(cmd_word[7:0])) decode_word(it.last);
                    else if (it.last) conclude(rpsd_pkg::ST_CMD, 1'b1);
                end
                rpsd_pkg::PH_LIT: begin
                    if (lits_left > 1) begin
                        if (it.last) conclude(rpsd_pkg::ST_LIT, 1'b1);
                        else begin
                            emit(b);
                            lits_left--;
                        end
                    end else begin
                        emit(b);
                        lits_left = 0;
                        literals_finished(it.last);
                    end
                end
                default: begin
                    res.status = verdict;
                    if (it.last) restart();
                end
            endcase
        end
        expected_bytes = {expected_bytes, res};
    endtask

    // stream building
    task automatic put(input logic cmd, input logic [7:0] b, input logic last);
        item_t it;
        it.cmd = cmd; it.data = b; it.last = last;
        pending_items = {pending_items, it};
    endtask

    task automatic put_header(input logic [23:0] sz);
        put(0, 8'h10, 0); put(0, 8'hFB, 0);
        put(0, sz[23:16], 0); put(0, sz[15:8], 0); put(0, sz[7:0], 0);
    endtask

    task automatic put_pulls(input int n);
        repeat (n) put(1, 8'($urandom), 1'($urandom));
    endtask

    // mostly well-formed stream with random content; corrupt picks an error mode
    task automatic gen_stream(input int corrupt);
        int unsigned made, target, n, lit, len, offs, kind;
        logic [7:0] c;
        target = $urandom_range(8, 60);
        if (corrupt == 1) target = target + $urandom_range(1, 4);
        put_header(24'(target));
        made = 0;
        while (made + 4 < target - (corrupt == 1 ? 4 : 0) && made < target) begin
            kind = $urandom_range(0, 3);
            if (made < 4 || kind == 3) begin
                c = 8'hE0;
                put(0, c, 0);
                for (n = 0; n < 4; n++) put(0, 8'($urandom), 0);
                made += 4;
            end else begin
                lit = $urandom_range(0, 3);
                offs = $urandom_range(1, made);
                if (kind == 0) begin
                    len = $urandom_range(3, 10);
                    if (made + lit + len > target) len = 3;
                    put(0, 8'(((offs - 1) >> 3 & 8'h60) | ((len - 3) << 2) | lit), 0);
                    put(0, 8'(offs - 1), 0);
                end else if (kind == 1) begin
                    len = $urandom_range(4, 12);
                    put(0, 8'(8'h80 | (len - 4)), 0);
                    put(0, 8'((lit << 6) | ((offs - 1) >> 8)), 0);
                    put(0, 8'(offs - 1), 0);
                end else begin
                    len = $urandom_range(5, 12);
                    put(0, 8'(8'hC0 | lit), 0);
                    put(0, 8'((offs - 1) >> 8), 0);
                    put(0, 8'(offs - 1), 0);
                    put(0, 8'(len - 5), 0);
                end
                for (n = 0; n < lit; n++) put(0, 8'($urandom), 0);
                if ($urandom_range(0, 9) == 0) put(0, 8'($urandom), 0);
                if ($urandom_range(0, 9) == 0) put(1, 8'h00, 0);
                put_pulls(len);
                made += lit + len;
            end
        end
        lit = (target > made) ? ((target - made) > 3 ? 3 : target - made) : 0;
        if (corrupt == 2) begin
            put(0, 8'h05, 1);
            return;
        end
        put(0, 8'(8'hFC | lit), (lit == 0 && corrupt != 3));
        for (n = 0; n < lit; n++) put(0, 8'($urandom), (n == lit - 1 && corrupt != 3));
        if (corrupt == 3 || $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(0, 3)) put(0, 8'($urandom), 0);
            put(0, 8'($urandom), 1);
        end
    endtask

    initial begin
        int k;
        restart();
        // directed: header faults, truncations, extreme fields
        put(0, 8'h11, 1);
        put(0, 8'h10, 1);
        put(0, 8'h10, 0); put(0, 8'hFA, 0); put(0, 8'hFF, 1);
        put(0, 8'h10, 0); put(0, 8'hFB, 0); put(0, 8'h00, 1);
        put(0, 8'h10, 0); put(0, 8'hFB, 0); put(0, 8'hFF, 0); put(0, 8'hFF, 0); put(0, 8'hFF, 1);
        put(1, 8'hFF, 1);
        put_header(24'd4); put(0, 8'hFF, 1);
        put_header(24'd8); put(0, 8'hE0, 0); put(0, 8'hAA, 0); put(0, 8'h55, 1);
        put_header(24'd3); put(0, 8'hE1, 0); put(0, 8'h00, 1);
        put_header(24'd20); put(0, 8'hFB, 0);
        put_header(24'd10); put(0, 8'hE0, 0);
        for (k = 0; k < 4; k++) put(0, 8'(8'hF0 + k), 0);
        put(0, 8'h7C, 0); put(0, 8'hFF, 0);
        put(0, 8'h00, 0); put(0, 8'h03, 0); put(1, 8'h00, 0);
        put_pulls(3); put(0, 8'hFC, 0); put(0, 8'h12, 1);
        put_header(24'd12); put(0, 8'hE0, 0); put_pulls(0);
        for (k = 0; k < 4; k++) put(0, 8'(k), 0);
        put(0, 8'hBF, 0); put(0, 8'h00, 1);
        put_header(24'd12); put(0, 8'hE0, 0);
        for (k = 0; k < 4; k++) put(0, 8'(k), 0);
        put(0, 8'hDF, 0); put(0, 8'hFF, 0); put(0, 8'hFF, 0); put(0, 8'hFF, 1);
        put_header(24'd9); put(0, 8'hE0, 0);
        for (k = 0; k < 4; k++) put(0, 8'(k), 0);
        put(0, 8'hC0, 0); put(0, 8'h00, 0); put(0, 8'h00, 0); put(0, 8'h00, 1);
        put_pulls(5);
        // random streams, mostly well formed
        while (pending_items.size() < 720) begin
            k = $urandom_range(0, 9);
            if (k < 6) gen_stream(0);
            else if (k == 6) gen_stream(1);
            else if (k == 7) gen_stream(2);
            else if (k == 8) gen_stream(3);
            else repeat ($urandom_range(1, 6))
                put($urandom_range(0, 4) == 0, 8'($urandom), $urandom_range(0, 5) == 0);
        end
        put_header(24'd4); put(0, 8'hE0, 0);
        for (k = 0; k < 4; k++) put(0, 8'(k), 0);
        put(0, 8'hFC, 1);
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict({s_cmd, s_in_byte, s_in_last});
                src_gap <= gap_len();
            end
            if (!s_valid || s_ready) begin
                if (src_gap == 0 && pending_items.size() > 0) begin
                    s_valid <= 1'b1;
                    {s_cmd, s_in_byte, s_in_last} <= pending_items.pop_front();
                end else begin
                    s_valid <= 1'b0;
                    if (!(s_valid && s_ready) && src_gap > 0) src_gap <= src_gap - 1;
                    if (pending_items.size() == 0) stim_done <= 1'b1;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        dec_result_t got, want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_out_byte, m_out_valid, m_status, m_stream_end};
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    errors++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (got.byte_out !== want.byte_out) begin
                        $display("%0t: out_byte expected %h actual %h", $time,
                                 want.byte_out, got.byte_out);
                        errors++;
                    end
                    if (got.byte_valid !== want.byte_valid) begin
                        $display("%0t: out_valid expected %b actual %b", $time,
                                 want.byte_valid, got.byte_valid);
                        errors++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, got.status);
                        errors++;
                    end
                    if (got.ends !== want.ends) begin
                        $display("%0t: stream_end expected %b actual %b", $time,
                                 want.ends, got.ends);
                        errors++;
                    end
                end
            end
            if (snk_gap > 0) begin
                m_ready <= 1'b0;
                snk_gap <= snk_gap - 1;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) snk_gap <= gap_len();
            end
        end
    end

    // watchdog and end of run
    initial begin
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            if (stim_done && !s_valid && expected_bytes.size() == 0) begin
                repeat (10) @(posedge aclk);
                if (errors == 0 && expected_bytes.size() == 0) begin
                    $display("Testbench completed without errors");
                end else begin
                    $display("Testbench completed WITH ERRORS");
                end
                $finish;
            end
        end
    end
endmodule
